[design/mbd_pkg.sv]
// mbd_pkg: shared types, constants and helper functions of the modbus register frame decoder
// used by the channel interfaces and the decoder top level; depends on nothing else
`default_nettype none

package mbd_pkg;

  // sizing
  localparam int MAX_REGISTER    = 126;
  localparam int MAX_FRAME_BYTES = 512;
  localparam int POS_W           = $clog2(MAX_FRAME_BYTES);
  localparam int LEN_W           = 9;
  localparam int CMP_W           = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;
  localparam int REG_IDX_W       = 7;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 9;
  localparam int NUM_SWITCHES    = 5;

  // protocol constants
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [7:0]  FN_READ_HOLD   = 8'h03;
  localparam logic [7:0]  HEALTH_COUNT   = 8'h02;
  localparam logic [15:0] TEMP_OFFSET    = 16'd40;
  localparam logic [16:0] CURRENT_OFFSET = 17'd30000;
  localparam logic [7:0]  SWITCH_FIRST   = 8'h52;
  localparam logic [7:0]  SWITCH_LAST    = 8'h56;
  localparam logic [6:0]  TEMP_CELL_LO   = 7'h30;
  localparam logic [6:0]  TEMP_CELL_HI   = 7'h37;
  localparam logic [6:0]  TEMP_MOS       = 7'h43;
  localparam logic [6:0]  TEMP_AMBIENT   = 7'h45;
  localparam logic [6:0]  TEMP_EXT_LO    = 7'h5A;
  localparam logic [6:0]  TEMP_EXT_HI    = 7'h5C;
  localparam logic [6:0]  CURRENT_MAIN   = 7'h39;
  localparam logic [6:0]  CURRENT_AUX    = 7'h60;
  localparam int          HEALTH_WORD_POS = 4;

  // configuration register reset values
  localparam logic [7:0]       SLAVE_ADDR_RST  = 8'd81;
  localparam logic [LEN_W-1:0] MIN_HEADED_RST  = 9'd259;
  localparam logic [LEN_W-1:0] MIN_BARE_RST    = 9'd256;
  localparam logic [LEN_W-1:0] MIN_HEALTH_RST  = 9'd7;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLAVE_ADDRESS = 2'd0,
    CFG_MIN_HEADED    = 2'd1,
    CFG_MIN_BARE      = 2'd2,
    CFG_MIN_HEALTH    = 2'd3
  } cfg_idx_t;

  // frame mode, one-hot
  typedef enum logic [3:0] {
    MODE_UNDECIDED = 4'b0001,
    MODE_HEADED    = 4'b0010,
    MODE_BARE      = 4'b0100,
    MODE_HEALTH    = 4'b1000
  } mode_t;

  // frame verdict
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC     = 2'd1,
    ST_LENGTH  = 2'd2,
    ST_COMMAND = 2'd3
  } status_t;

  localparam logic ITEM_WORD   = 1'b0;
  localparam logic ITEM_STATUS = 1'b1;

  // one result beat
  typedef struct packed {
    logic                    item_type;
    logic [REG_IDX_W-1:0]    register_index;
    logic [15:0]             raw_word;
    logic signed [16:0]      decoded_value;
    logic [1:0]              frame_status;
    logic [NUM_SWITCHES-1:0] switch_flags;
    logic                    last_of_run;
  } result_t;

  // crc-16 over one byte, lsb first, reflected poly
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // engineering offset by register class
  function automatic logic signed [16:0] decode_word(input logic [REG_IDX_W-1:0] rg,
                                                     input logic [15:0] w);
    logic        is_temp;
    logic        is_curr;
    logic [15:0] t;
    is_temp = (rg >= TEMP_CELL_LO && rg <= TEMP_CELL_HI) || rg == TEMP_MOS ||
              rg == TEMP_AMBIENT || (rg >= TEMP_EXT_LO && rg <= TEMP_EXT_HI);
    is_curr = (rg == CURRENT_MAIN) || (rg == CURRENT_AUX);
    t = w - TEMP_OFFSET;
    if (is_temp) begin
      return {t[15], t};
    end else if (is_curr) begin
      return {1'b0, w} - CURRENT_OFFSET;
    end
    return {1'b0, w};
  endfunction

endpackage

`default_nettype wire

[design/mbd_in_if.sv]
// mbd_in_if: byte channel into the decoder, valid/ready with the frame byte fields
// depends on mbd_pkg for field widths
`default_nettype none

interface mbd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [7:0]                  frame_byte;
  logic [mbd_pkg::LEN_W-1:0]   frame_length;
  logic                        end_of_frame;

  modport source (output valid, kind, frame_byte, frame_length, end_of_frame, input ready);
  modport sink   (input valid, kind, frame_byte, frame_length, end_of_frame, output ready);
endinterface

`default_nettype wire

[design/mbd_out_if.sv]
// mbd_out_if: result channel out of the decoder, valid/ready with word and status fields
// depends on mbd_pkg for field widths
`default_nettype none

interface mbd_out_if;
  logic                               valid;
  logic                               ready;
  logic                               item_type;
  logic [mbd_pkg::REG_IDX_W-1:0]      register_index;
  logic [15:0]                        raw_word;
  logic signed [16:0]                 decoded_value;
  logic [1:0]                         frame_status;
  logic [mbd_pkg::NUM_SWITCHES-1:0]   switch_flags;
  logic                               last_of_run;

  modport source (output valid, item_type, register_index, raw_word, decoded_value,
                  frame_status, switch_flags, last_of_run, input ready);
  modport sink   (input valid, item_type, register_index, raw_word, decoded_value,
                  frame_status, switch_flags, last_of_run, output ready);
endinterface

`default_nettype wire

[design/mbd_cfg_if.sv]
// mbd_cfg_if: configuration write channel, valid/ready with register index and data
// depends on mbd_pkg for field widths
`default_nettype none

interface mbd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mbd_pkg::CFG_IDX_W-1:0]    index;
  logic [mbd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/modbus_register_frame_decoder_top.sv]
// modbus_register_frame_decoder_top: byte-wise modbus rtu response decoder with crc-16 check
// depends on mbd_pkg and the mbd_in_if, mbd_out_if and mbd_cfg_if interfaces
//
//  channel   dir  beat
//  in_bus    in   one frame byte with kind, frame length and end-of-frame flag
//  out_bus   out  one register word item or one end-of-frame status item
//  cfg_bus   in   one register write: index 0..3, data up to 9 bits
//
// one byte is decoded per cycle while in_bus.ready is high: crc step, word assembly and verdict sit in one
// combinational pass from the byte beat into a 4-entry result queue.
// a byte that yields a word and the status writes both into the queue; in_bus.ready
// drops while fewer than two queue entries are free, so an out_bus stall backs up.
// rst_n is synchronous active low; it empties the queue and restores register defaults.
// cfg_bus.ready is always high.
`default_nettype none

module modbus_register_frame_decoder_top (
  input  wire  clk,
  input  wire  rst_n,
  mbd_in_if.sink    in_bus,
  mbd_out_if.source out_bus,
  mbd_cfg_if.sink   cfg_bus
);

  // configuration registers
  logic [7:0]                  slave_addr_r;
  logic [mbd_pkg::LEN_W-1:0]   min_headed_r;
  logic [mbd_pkg::LEN_W-1:0]   min_bare_r;
  logic [mbd_pkg::LEN_W-1:0]   min_health_r;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= mbd_pkg::SLAVE_ADDR_RST;
      min_headed_r <= mbd_pkg::MIN_HEADED_RST;
      min_bare_r   <= mbd_pkg::MIN_BARE_RST;
      min_health_r <= mbd_pkg::MIN_HEALTH_RST;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        mbd_pkg::CFG_SLAVE_ADDRESS: slave_addr_r <= cfg_bus.data[7:0];
        mbd_pkg::CFG_MIN_HEADED:    min_headed_r <= cfg_bus.data[mbd_pkg::LEN_W-1:0];
        mbd_pkg::CFG_MIN_BARE:      min_bare_r   <= cfg_bus.data[mbd_pkg::LEN_W-1:0];
        mbd_pkg::CFG_MIN_HEALTH:    min_health_r <= cfg_bus.data[mbd_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // per-frame state
  logic [15:0]                        crc_r, crc_nxt;
  logic [mbd_pkg::POS_W-1:0]          pos_r, pos_nxt;
  mbd_pkg::mode_t                     mode_r, mode_nxt;
  logic [7:0]                         held_r, held_nxt;
  logic [7:0]                         crc_lo_r, crc_lo_nxt;
  logic [mbd_pkg::NUM_SWITCHES-1:0]   sw_r, sw_nxt;
  logic [15:0]                        health_r, health_nxt;
  logic                               hm_r, hm_nxt;

  // result queue
  mbd_pkg::result_t                   fifo_r [mbd_pkg::FIFO_DEPTH];
  logic [mbd_pkg::FIFO_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [mbd_pkg::FIFO_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [mbd_pkg::FIFO_CNT_W-1:0]     cnt_r, cnt_nxt;

  logic in_fire, out_fire;

  assign in_bus.ready = (cnt_r <= mbd_pkg::FIFO_CNT_W'(mbd_pkg::FIFO_DEPTH - 2));
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign out_fire     = out_bus.valid && out_bus.ready;

  // decode of one byte
  logic [15:0]                        crc_e;
  mbd_pkg::mode_t                     mode_e;
  logic [7:0]                         crc_lo_e;
  logic [mbd_pkg::NUM_SWITCHES-1:0]   sw_e;
  logic [15:0]                        health_e;
  logic                               hm_e;
  logic                               first;
  logic [mbd_pkg::CMP_W-1:0]          pos_x, flen_x;
  logic                               in_data;
  logic [mbd_pkg::POS_W-1:0]          rel;
  logic [mbd_pkg::POS_W-2:0]          reg_full;
  logic [7:0]                         sw_ofs;
  logic [15:0]                        word;
  logic [15:0]                        recv;
  logic                               len_ok;
  logic                               word_v;
  logic                               stat_v;
  mbd_pkg::status_t                   status;
  mbd_pkg::result_t                   word_item, stat_item;

  always_comb begin
    first    = (pos_r == '0);
    crc_e    = first ? mbd_pkg::CRC_INIT : crc_r;
    mode_e   = first ? (in_bus.kind ? mbd_pkg::MODE_HEALTH : mbd_pkg::MODE_UNDECIDED)
                     : mode_r;
    crc_lo_e = first ? 8'h00 : crc_lo_r;
    sw_e     = first ? '0 : sw_r;
    health_e = first ? 16'h0000 : health_r;
    hm_e     = first ? 1'b0 : hm_r;

    pos_x   = mbd_pkg::CMP_W'(pos_r);
    flen_x  = mbd_pkg::CMP_W'(in_bus.frame_length);
    in_data = (pos_x + mbd_pkg::CMP_W'(2)) < flen_x;
    len_ok  = (pos_x + mbd_pkg::CMP_W'(1)) == flen_x;

    crc_nxt    = in_data ? mbd_pkg::crc_feed(crc_e, in_bus.frame_byte) : crc_e;
    crc_lo_nxt = ((pos_x + mbd_pkg::CMP_W'(2)) == flen_x) ? in_bus.frame_byte : crc_lo_e;
    held_nxt   = in_bus.frame_byte;
    word       = {held_r, in_bus.frame_byte};

    mode_nxt   = mode_e;
    sw_nxt     = sw_e;
    health_nxt = health_e;
    hm_nxt     = hm_e;
    word_v     = 1'b0;
    rel        = '0;
    reg_full   = '0;
    sw_ofs     = 8'h00;

    if (mode_e == mbd_pkg::MODE_HEALTH) begin
      // header check and health word capture
      if ((pos_r == mbd_pkg::POS_W'(0) && in_bus.frame_byte != slave_addr_r) ||
          (pos_r == mbd_pkg::POS_W'(1) && in_bus.frame_byte != mbd_pkg::FN_READ_HOLD) ||
          (pos_r == mbd_pkg::POS_W'(2) && in_bus.frame_byte != mbd_pkg::HEALTH_COUNT)) begin
        hm_nxt = 1'b1;
      end
      if (pos_r == mbd_pkg::POS_W'(mbd_pkg::HEALTH_WORD_POS)) begin
        health_nxt = word;
      end
    end else begin
      // headed or bare decision on the second byte
      if (pos_r == mbd_pkg::POS_W'(1) && mode_e == mbd_pkg::MODE_UNDECIDED) begin
        if (in_bus.frame_length >= min_headed_r && held_r == slave_addr_r &&
            in_bus.frame_byte == mbd_pkg::FN_READ_HOLD) begin
          mode_nxt = mbd_pkg::MODE_HEADED;
        end else if (in_bus.frame_length >= min_bare_r) begin
          mode_nxt = mbd_pkg::MODE_BARE;
        end
      end
      // word completes on the odd byte of the data region
      if ((mode_nxt == mbd_pkg::MODE_HEADED || mode_nxt == mbd_pkg::MODE_BARE) && in_data) begin
        if (mode_nxt == mbd_pkg::MODE_HEADED) begin
          rel = pos_r - mbd_pkg::POS_W'(3);
        end else begin
          rel = pos_r;
        end
        reg_full = rel[mbd_pkg::POS_W-1:1];
        if ((mode_nxt == mbd_pkg::MODE_BARE || pos_r >= mbd_pkg::POS_W'(3)) && rel[0] &&
            (reg_full <= (mbd_pkg::POS_W-1)'(mbd_pkg::MAX_REGISTER))) begin
          word_v = 1'b1;
          if (8'(reg_full) >= mbd_pkg::SWITCH_FIRST && 8'(reg_full) <= mbd_pkg::SWITCH_LAST &&
              word != 16'h0000) begin
            sw_ofs = 8'(reg_full) - mbd_pkg::SWITCH_FIRST;
            sw_nxt = sw_e | (mbd_pkg::NUM_SWITCHES'(1) << sw_ofs[2:0]);
          end
        end
      end
    end

    // frame verdict on the last byte
    recv   = {in_bus.frame_byte, crc_lo_nxt};
    stat_v = in_bus.end_of_frame;
    if (mode_nxt == mbd_pkg::MODE_HEALTH) begin
      if (in_bus.frame_length < min_health_r || in_bus.frame_length < mbd_pkg::LEN_W'(2) ||
          !len_ok) begin
        status = mbd_pkg::ST_LENGTH;
      end else if (recv != crc_nxt) begin
        status = mbd_pkg::ST_CRC;
      end else if (hm_nxt || pos_r < mbd_pkg::POS_W'(2)) begin
        status = mbd_pkg::ST_COMMAND;
      end else begin
        status = mbd_pkg::ST_OK;
      end
    end else begin
      if (mode_nxt == mbd_pkg::MODE_UNDECIDED || !len_ok) begin
        status = mbd_pkg::ST_LENGTH;
      end else if (mode_nxt == mbd_pkg::MODE_HEADED && recv != crc_nxt) begin
        status = mbd_pkg::ST_CRC;
      end else begin
        status = mbd_pkg::ST_OK;
      end
    end

    // next position, saturating on an overlong frame
    if (in_bus.end_of_frame) begin
      pos_nxt = '0;
    end else if (pos_r < mbd_pkg::POS_W'(mbd_pkg::MAX_FRAME_BYTES - 1)) begin
      pos_nxt = pos_r + mbd_pkg::POS_W'(1);
    end else begin
      pos_nxt = pos_r;
    end

    // result beats
    word_item.item_type      = mbd_pkg::ITEM_WORD;
    word_item.register_index = reg_full[mbd_pkg::REG_IDX_W-1:0];
    word_item.raw_word       = word;
    word_item.decoded_value  = mbd_pkg::decode_word(reg_full[mbd_pkg::REG_IDX_W-1:0], word);
    word_item.frame_status   = mbd_pkg::ST_OK;
    word_item.switch_flags   = '0;
    word_item.last_of_run    = 1'b0;

    stat_item.item_type      = mbd_pkg::ITEM_STATUS;
    stat_item.register_index = '0;
    stat_item.decoded_value  = '0;
    stat_item.frame_status   = status;
    stat_item.last_of_run    = 1'b1;
    if (mode_nxt == mbd_pkg::MODE_HEALTH) begin
      stat_item.raw_word     = health_nxt;
      stat_item.switch_flags = '0;
    end else begin
      stat_item.raw_word     = 16'h0000;
      stat_item.switch_flags = sw_nxt;
    end
  end

  // frame state update on an accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= mbd_pkg::CRC_INIT;
      pos_r    <= '0;
      mode_r   <= mbd_pkg::MODE_UNDECIDED;
      held_r   <= 8'h00;
      crc_lo_r <= 8'h00;
      sw_r     <= '0;
      health_r <= 16'h0000;
      hm_r     <= 1'b0;
    end else if (in_fire) begin
      crc_r    <= crc_nxt;
      pos_r    <= pos_nxt;
      mode_r   <= mode_nxt;
      held_r   <= held_nxt;
      crc_lo_r <= crc_lo_nxt;
      sw_r     <= sw_nxt;
      health_r <= health_nxt;
      hm_r     <= hm_nxt;
    end
  end

  // queue pointers and fill count
  logic [1:0] wr_n;

  always_comb begin
    wr_n       = in_fire ? ({1'b0, word_v} + {1'b0, stat_v}) : 2'd0;
    wr_ptr_nxt = wr_ptr_r + mbd_pkg::FIFO_PTR_W'(wr_n);
    rd_ptr_nxt = rd_ptr_r + mbd_pkg::FIFO_PTR_W'(out_fire);
    cnt_nxt    = cnt_r + mbd_pkg::FIFO_CNT_W'(wr_n) - mbd_pkg::FIFO_CNT_W'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage, word beat ahead of status beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (word_v) begin
        fifo_r[wr_ptr_r] <= word_item;
        if (stat_v) begin
          fifo_r[wr_ptr_r + mbd_pkg::FIFO_PTR_W'(1)] <= stat_item;
        end
      end else if (stat_v) begin
        fifo_r[wr_ptr_r] <= stat_item;
      end
    end
  end

  // output beat from queue head
  mbd_pkg::result_t head;

  assign head                   = fifo_r[rd_ptr_r];
  assign out_bus.valid          = (cnt_r != '0);
  assign out_bus.item_type      = head.item_type;
  assign out_bus.register_index = head.register_index;
  assign out_bus.raw_word       = head.raw_word;
  assign out_bus.decoded_value  = head.decoded_value;
  assign out_bus.frame_status   = head.frame_status;
  assign out_bus.switch_flags   = head.switch_flags;
  assign out_bus.last_of_run    = head.last_of_run;

endmodule

`default_nettype wire
